// ===== hw/rtl/egc_pkg.sv =====
`default_nettype none

package egc_pkg;

   // Fixed widths of the stream fields and the control registers.
   localparam int FLOOR_W     = 5;
   localparam int CARS_W      = 4;
   localparam int CAR_OUT_W   = 3;
   localparam int KIND_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;

   // Reset values of the control registers.
   localparam logic [FLOOR_W-1:0] FLOORS_RESET = 5'd10;
   localparam logic [CARS_W-1:0]  CARS_RESET   = 4'd2;

   // The smallest floor count that is ever served.
   localparam logic [FLOOR_W-1:0] MIN_FLOORS = 5'd2;

   // Register indexes, taken from the word address bit of the CSR port.
   localparam logic REG_FLOORS = 1'b0;
   localparam logic REG_CARS   = 1'b1;

   // Request actions.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_CALL = 1'b1;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_REPORT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REJECT   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_DISP,
      ST_REJECT
   } egc_state_type;

   // Per-car flags that travel with the car's floor and request sets.
   typedef struct packed {
      logic idle;
      logic dir_up;
   } car_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/egc_car_step.sv =====
`default_nettype none

// One tick of a single car: direction choice, target search and, unless it has no requests, one move or a door cycle.
module egc_car_step import egc_pkg::*; #(
   parameter int MAX_FLOORS = 16,
   localparam int PW = $clog2(MAX_FLOORS + 1),
   localparam int IW = $clog2(MAX_FLOORS)
) (
   input  logic [PW-1:0]         pos_i,
   input  car_flags_type         flags_i,
   input  logic [MAX_FLOORS-1:0] up_set_i,
   input  logic [MAX_FLOORS-1:0] dn_set_i,
   output logic [PW-1:0]         pos_o,
   output car_flags_type         flags_o,
   output logic [MAX_FLOORS-1:0] up_set_o,
   output logic [MAX_FLOORS-1:0] dn_set_o,
   output logic                  door_o
);

   logic                  up_empty;
   logic                  dn_empty;
   logic                  dir_next;
   logic [MAX_FLOORS-1:0] up_low;
   logic [MAX_FLOORS-1:0] dn_rev;
   logic [MAX_FLOORS-1:0] dn_rev_low;
   logic [MAX_FLOORS-1:0] dn_high;
   logic [IW-1:0]         lo_idx;
   logic [IW-1:0]         hi_idx;
   logic [PW-1:0]         tgt_floor;

   assign up_empty = (up_set_i == '0);
   assign dn_empty = (dn_set_i == '0);

   // The lowest pending up request is isolated directly; the highest pending
   // down request is isolated on the bit-reversed set.
   assign up_low = up_set_i & (~up_set_i + 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_FLOORS; i++) begin
         dn_rev[i] = dn_set_i[MAX_FLOORS-1-i];
      end
   end

   assign dn_rev_low = dn_rev & (~dn_rev + 1'b1);

   always_comb begin
      for (int i = 0; i < MAX_FLOORS; i++) begin
         dn_high[i] = dn_rev_low[MAX_FLOORS-1-i];
      end
   end

   always_comb begin
      lo_idx = '0;
      hi_idx = '0;
      for (int i = 0; i < MAX_FLOORS; i++) begin
         if (up_low[i]) begin
            lo_idx = lo_idx | IW'(i);
         end
         if (dn_high[i]) begin
            hi_idx = hi_idx | IW'(i);
         end
      end
   end

   always_comb begin
      if (flags_i.dir_up) begin
         dir_next = !up_empty;
      end else begin
         dir_next = dn_empty;
      end
   end

   assign tgt_floor = dir_next ? (PW'(lo_idx) + PW'(1)) : (PW'(hi_idx) + PW'(1));

   always_comb begin
      pos_o          = pos_i;
      flags_o        = flags_i;
      up_set_o       = up_set_i;
      dn_set_o       = dn_set_i;
      door_o         = 1'b0;
      if (up_empty && dn_empty) begin
         flags_o.idle = 1'b1;
      end else begin
         flags_o.idle   = 1'b0;
         flags_o.dir_up = dir_next;
         if (pos_i == tgt_floor) begin
            door_o = 1'b1;
            if (dir_next) begin
               up_set_o = up_set_i & ~up_low;
            end else begin
               dn_set_o = dn_set_i & ~dn_high;
            end
         end else if (tgt_floor > pos_i) begin
            pos_o = pos_i + PW'(1);
         end else begin
            pos_o = pos_i - PW'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/elevator_group_controller_core.sv =====
`default_nettype none

// Elevator group controller. Each request transaction is either a tick
// (tuser bit 0 low), which steps every active car and returns one report per
// car, or a hall call (tuser bit 0 high, floor in tdata), which returns one
// dispatch or reject transaction. The last response of a request carries
// tlast. All per-car state lives in a single synchronous memory with a
// registered read; an entry that has never been written reads as a car parked
// at floor 1, heading up, idle and with no requests, so no clearing pass runs
// after reset. Requests are taken one at a time, only while the controller is
// idle. During a tick the read of the next car overlaps the update and
// write-back of the current one. A hall call is accepted, scans the active
// cars for the nearest idle car, or the nearest car if none is idle, and then
// updates the chosen car; a rejected call only returns its reject. Each
// response cycle may stretch while the response register is held by
// back-pressure. The control registers lie at byte addresses 0 (floors in
// use) and 4 (cars in use) and should only be written while the controller
// is idle.
module elevator_group_controller_core import egc_pkg::*; #(
   parameter int MAX_FLOORS = 16,
   parameter int MAX_CARS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] call_floor, [7:5] zero
   input  logic [0:0]            req_tuser,   // [0] action
   // Response stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] car, [7:3] car_floor,
                                              // [8] heading_up, [9] is_idle,
                                              // [10] door_cycled, [15:11] zero
   output logic [KIND_W-1:0]     rsp_tuser,   // [1:0] kind
   output logic                  rsp_tlast,
   // Control register port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int PW       = $clog2(MAX_FLOORS + 1);
   localparam int CW       = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int DW       = (PW > FLOOR_W) ? PW : FLOOR_W;
   localparam int EW       = PW + 2 + 2 * MAX_FLOORS;
   localparam int FLAGS_LO = PW;
   localparam int UP_LO    = PW + 2;
   localparam int DN_LO    = PW + 2 + MAX_FLOORS;

   // Entry layout, lowest bits first: floor, flags, up set, down set.
   localparam logic [EW-1:0] ENTRY_RESET =
      {{(2 * MAX_FLOORS){1'b0}}, 1'b1, 1'b1, PW'(1)};

   // ------------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------------
   logic [FLOOR_W-1:0] floors_ff;
   logic [CARS_W-1:0]  cars_ff;
   logic               csr_wr;
   logic [CW-1:0]      last_car;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         floors_ff <= FLOORS_RESET;
         cars_ff   <= CARS_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_FLOORS: floors_ff <= csr_pwdata[FLOOR_W-1:0];
            REG_CARS:   cars_ff   <= csr_pwdata[CARS_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FLOORS: csr_prdata = CSR_DATA_W'(floors_ff);
         REG_CARS:   csr_prdata = CSR_DATA_W'(cars_ff);
      endcase
   end

   // Index of the highest active car, with the car count saturated into the
   // range that the memory holds.
   always_comb begin
      if (cars_ff == '0) begin
         last_car = '0;
      end else if (32'(cars_ff) >= MAX_CARS) begin
         last_car = CW'(MAX_CARS - 1);
      end else begin
         last_car = CW'(cars_ff - CARS_W'(1));
      end
   end

   // ------------------------------------------------------------------------
   // Car state memory
   // ------------------------------------------------------------------------
   logic [EW-1:0]       car_mem [MAX_CARS];
   logic [MAX_CARS-1:0] vld_ff;
   logic                rd_en;
   logic [CW-1:0]       rd_addr;
   logic [EW-1:0]       rd_data_ff;
   logic                rd_vld_ff;
   logic                wr_en;
   logic [CW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [EW-1:0]       entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         car_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= car_mem[rd_addr];
      end
   end

   // A cleared valid bit makes the entry read as its reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign entry = rd_vld_ff ? rd_data_ff : ENTRY_RESET;

   logic [PW-1:0]         ent_pos;
   car_flags_type         ent_flags;
   logic [MAX_FLOORS-1:0] ent_up;
   logic [MAX_FLOORS-1:0] ent_dn;

   assign ent_pos   = entry[PW-1:0];
   assign ent_flags = entry[FLAGS_LO +: 2];
   assign ent_up    = entry[UP_LO +: MAX_FLOORS];
   assign ent_dn    = entry[DN_LO +: MAX_FLOORS];

   // ------------------------------------------------------------------------
   // Tick update of one car
   // ------------------------------------------------------------------------
   logic [PW-1:0]         stp_pos;
   car_flags_type         stp_flags;
   logic [MAX_FLOORS-1:0] stp_up;
   logic [MAX_FLOORS-1:0] stp_dn;
   logic                  stp_door;

   egc_car_step #(
      .MAX_FLOORS (MAX_FLOORS)
   ) u_step (
      .pos_i    (ent_pos),
      .flags_i  (ent_flags),
      .up_set_i (ent_up),
      .dn_set_i (ent_dn),
      .pos_o    (stp_pos),
      .flags_o  (stp_flags),
      .up_set_o (stp_up),
      .dn_set_o (stp_dn),
      .door_o   (stp_door)
   );

   // ------------------------------------------------------------------------
   // Request decode and call distance
   // ------------------------------------------------------------------------
   logic               req_fire;
   logic               req_action;
   logic [FLOOR_W-1:0] req_floor;
   logic               floor_ok;

   assign req_fire   = req_tvalid && req_tready;
   assign req_action = req_tuser[0];
   assign req_floor  = req_tdata[FLOOR_W-1:0];

   // A call is served when 1 <= floor <= max(2, min(floors in use, MAX_FLOORS)).
   assign floor_ok = (req_floor != '0) &&
                     ((req_floor <= MIN_FLOORS) ||
                      ((req_floor <= floors_ff) && (32'(req_floor) <= MAX_FLOORS)));

   logic [FLOOR_W-1:0]    fl_ff;
   logic [FLOOR_W-1:0]    fl_in;
   logic [DW-1:0]         pos_w;
   logic [DW-1:0]         fl_w;
   logic [DW-1:0]         call_dist;
   logic                  call_above;
   logic [MAX_FLOORS-1:0] call_bit;

   assign pos_w      = DW'(ent_pos);
   assign fl_w       = DW'(fl_ff);
   assign call_dist  = (pos_w > fl_w) ? (pos_w - fl_w) : (fl_w - pos_w);
   assign call_above = fl_w > pos_w;

   always_comb begin
      for (int i = 0; i < MAX_FLOORS; i++) begin
         call_bit[i] = (32'(fl_ff) == 32'(i + 1));
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   egc_state_type state_ff;
   egc_state_type state_in;
   logic [CW-1:0] cur_ff;
   logic [CW-1:0] cur_in;
   logic          cur_last;
   logic          out_free;

   // Nearest idle car and nearest car of all, gathered during the scan.
   logic          bi_found_ff;
   logic          bi_found_in;
   logic [CW-1:0] bi_idx_ff;
   logic [CW-1:0] bi_idx_in;
   logic [DW-1:0] bi_dist_ff;
   logic [DW-1:0] bi_dist_in;
   logic [CW-1:0] ba_idx_ff;
   logic [CW-1:0] ba_idx_in;
   logic [DW-1:0] ba_dist_ff;
   logic [DW-1:0] ba_dist_in;
   logic          take_idle;
   logic          take_any;
   logic [CW-1:0] chosen;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_load;
   logic [KIND_W-1:0]     rsp_kind_ff;
   logic [KIND_W-1:0]     rsp_kind_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;

   assign cur_last = (cur_ff == last_car);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Strict less-than keeps the lower-numbered car on a tie.
   assign take_idle = ent_flags.idle && (!bi_found_ff || (call_dist < bi_dist_ff));
   assign take_any  = (cur_ff == '0) || (call_dist < ba_dist_ff);

   always_comb begin
      if (take_idle) begin
         chosen = cur_ff;
      end else if (bi_found_ff) begin
         chosen = bi_idx_ff;
      end else if (take_any) begin
         chosen = cur_ff;
      end else begin
         chosen = ba_idx_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_TICK) begin
                  state_in = ST_TICK;
               end else if (floor_ok) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_REJECT;
               end
            end
         end
         ST_TICK: begin
            if (out_free && cur_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (cur_last) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP, ST_REJECT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = cur_ff;
      wr_data     = entry;
      cur_in      = cur_ff;
      fl_in       = fl_ff;
      bi_found_in = bi_found_ff;
      bi_idx_in   = bi_idx_ff;
      bi_dist_in  = bi_dist_ff;
      ba_idx_in   = ba_idx_ff;
      ba_dist_in  = ba_dist_ff;
      rsp_load    = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               fl_in       = req_floor;
               cur_in      = '0;
               bi_found_in = 1'b0;
               rd_en       = (req_action == ACT_TICK) || floor_ok;
            end
         end
         ST_TICK: begin
            if (out_free) begin
               wr_en       = 1'b1;
               wr_data     = {stp_dn, stp_up, stp_flags, stp_pos};
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_REPORT;
               rsp_data_in = RSP_DATA_W'({stp_door, stp_flags.idle, stp_flags.dir_up,
                                          FLOOR_W'(stp_pos), CAR_OUT_W'(cur_ff)});
               rsp_last_in = cur_last;
               if (!cur_last) begin
                  // Fetch the next car while this one is written back.
                  rd_en   = 1'b1;
                  rd_addr = cur_ff + CW'(1);
                  cur_in  = cur_ff + CW'(1);
               end
            end
         end
         ST_SCAN: begin
            if (take_idle) begin
               bi_found_in = 1'b1;
               bi_idx_in   = cur_ff;
               bi_dist_in  = call_dist;
            end
            if (take_any) begin
               ba_idx_in  = cur_ff;
               ba_dist_in = call_dist;
            end
            rd_en = 1'b1;
            if (cur_last) begin
               rd_addr = chosen;
               cur_in  = chosen;
            end else begin
               rd_addr = cur_ff + CW'(1);
               cur_in  = cur_ff + CW'(1);
            end
         end
         ST_DISP: begin
            if (out_free) begin
               wr_en = 1'b1;
               if (call_above) begin
                  wr_data = {ent_dn, ent_up | call_bit, ent_flags, ent_pos};
               end else begin
                  wr_data = {ent_dn | call_bit, ent_up, ent_flags, ent_pos};
               end
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_DISPATCH;
               rsp_data_in = RSP_DATA_W'({1'b0, ent_flags.idle, ent_flags.dir_up,
                                          FLOOR_W'(ent_pos), CAR_OUT_W'(cur_ff)});
               rsp_last_in = 1'b1;
            end
         end
         ST_REJECT: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = KIND_REJECT;
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         bi_found_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         bi_found_ff  <= bi_found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fl_ff      <= fl_in;
      bi_idx_ff  <= bi_idx_in;
      bi_dist_ff <= bi_dist_in;
      ba_idx_ff  <= ba_idx_in;
      ba_dist_ff <= ba_dist_in;
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------

   // The next car is never fetched from the entry being written back.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("car memory read and write hit the same entry");

   // A written entry is marked valid from the next cycle on.
   a_vld_after_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(wr_addr)])
      else $error("written car entry not marked valid");

   // Only tick reports may carry a door cycle.
   a_door_on_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_REPORT)) |-> !rsp_data_ff[10])
      else $error("door cycle flagged on a call response");

   // A call produces a single response, so it always closes the request.
   a_call_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_REPORT)) |-> rsp_last_ff)
      else $error("call response without tlast");

   // After a tick is accepted, the request port is not ready for another request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_action == ACT_TICK)) |=> !req_tready)
      else $error("request accepted while a tick is in progress");

endmodule

`default_nettype wire
